// ----- sv/arp_pkg.sv -----
// Package with the sizes, codes and constants of the ARP resolver.
`default_nettype none
package arp_pkg;

  localparam int CACHE_ENTRIES  = 16;
  localparam int PENDING_IPS    = 8;
  localparam int PENDING_PER_IP = 8;

  localparam int CIW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PIW  = (PENDING_IPS > 1) ? $clog2(PENDING_IPS) : 1;
  localparam int CNTW = $clog2(PENDING_PER_IP + 1);
  localparam int HDEPTH = PENDING_IPS * PENDING_PER_IP;
  localparam int HAW  = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int SMAX = (CACHE_ENTRIES > PENDING_IPS) ? CACHE_ENTRIES : PENDING_IPS;
  localparam int SW   = $clog2(SMAX + 1);

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RECV = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] FT_IPV4 = 2'd0;
  localparam logic [1:0] FT_ARP  = 2'd1;

  localparam logic [1:0] KIND_IPV4    = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;
  localparam logic [1:0] KIND_DELIVER = 2'd3;

  localparam logic [1:0] REG_OWN_MAC   = 2'd0;
  localparam logic [1:0] REG_OWN_IP    = 2'd1;
  localparam logic [1:0] REG_CACHE_LIFE = 2'd2;
  localparam logic [1:0] REG_PEND_LIFE = 2'd3;

  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [47:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] CACHE_LIFE_RST = 16'd30000;
  localparam logic [15:0] PEND_LIFE_RST  = 16'd5000;

endpackage
`default_nettype wire

// ----- sv/arp_resolver_with_pending_queue.sv -----
// ARP resolver with a cache, pending-datagram queues and an output register.
//
// Items enter on the in_* channel (in_valid_i, in_stall_o) and results leave on
// the out_* channel (out_valid_o, out_stall_i); an item moves when valid is high
// and stall is low. One item is worked on at a time and in_stall_o is high
// until it is finished. Configuration must be written by the user through
// cfg_we_i, cfg_idx_i and cfg_data_i only while the block is idle; the block
// itself does not enforce it. A send walks the cache memory, one entry per
// cycle, and on a miss also the pending memory. An ARP message walks both
// memories the same way and then reads one queued handle per result, in
// S_FLRD and S_FLEM for each. A tick reads every cache and pending entry and
// ages and writes back the valid ones. Results pass through one output
// register, so the next result may be prepared while the previous one waits;
// a stalled receiver holds the result and pauses the block. Reset empties the
// cache and the pending queues at once and restores the register defaults;
// no clearing pass is needed.
`default_nettype none
module arp_resolver_with_pending_queue import arp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [47:0] frame_dst_mac_i,
  input  wire logic [1:0]  frame_type_i,
  input  wire logic        payload_ok_i,
  input  wire logic [15:0] arp_opcode_i,
  input  wire logic [31:0] peer_ip_i,
  input  wire logic [47:0] peer_mac_i,
  input  wire logic [31:0] asked_ip_i,
  input  wire logic [15:0] datagram_handle_i,
  input  wire logic [15:0] elapsed_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       out_kind_o,
  output logic [47:0]      out_dst_mac_o,
  output logic [31:0]      out_target_ip_o,
  output logic [47:0]      out_target_mac_o,
  output logic [15:0]      out_handle_o,
  output logic             last_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CSCAN = 4'd1;
  localparam logic [3:0] S_CDONE = 4'd2;
  localparam logic [3:0] S_PSCAN = 4'd3;
  localparam logic [3:0] S_PDONE = 4'd4;
  localparam logic [3:0] S_FLRD  = 4'd5;
  localparam logic [3:0] S_FLEM  = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;
  localparam logic [3:0] S_TKC   = 4'd8;
  localparam logic [3:0] S_TKP   = 4'd9;

  logic [3:0] state_q, state_d;

  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q;
  logic [15:0] cache_life_q, pend_life_q;

  logic [1:0]  cmd_q, cmd_d;
  logic [31:0] ip_q, ip_d;
  logic [47:0] mac_q, mac_d;
  logic [15:0] hnd_q, hnd_d;
  logic [15:0] dly_q, dly_d;
  logic        reply_q, reply_d;

  logic [SW-1:0] cnt_q, cnt_d, chk_idx_q, chk_idx_d;
  logic          chk_vld_q, chk_vld_d;

  logic           hit_q, hit_d;
  logic [CIW-1:0] hit_idx_q, hit_idx_d;
  logic [47:0]    hit_mac_q, hit_mac_d;
  logic [15:0]    best_age_q, best_age_d;
  logic [CIW-1:0] best_idx_q, best_idx_d;
  logic           phit_q, phit_d;
  logic [PIW-1:0] phit_idx_q, phit_idx_d;

  logic [CACHE_ENTRIES-1:0] cv_q, cv_d;
  logic [PENDING_IPS-1:0]   pv_q, pv_d;
  logic [CNTW-1:0]          pc_q [PENDING_IPS];
  logic [CNTW-1:0]          pc_d [PENDING_IPS];

  logic [PIW-1:0]  fl_p_q, fl_p_d;
  logic [CNTW-1:0] fl_k_q, fl_k_d, fl_n_q, fl_n_d;

  logic [1:0]  res_kind_q, res_kind_d;
  logic [47:0] res_dst_q, res_dst_d;
  logic [31:0] res_tip_q, res_tip_d;
  logic [47:0] res_tmac_q, res_tmac_d;
  logic [15:0] res_hnd_q, res_hnd_d;

  logic        ov_q, ov_d, olast_q, olast_d;
  logic [1:0]  okind_q, okind_d;
  logic [47:0] odst_q, odst_d, otmac_q, otmac_d;
  logic [31:0] otip_q, otip_d;
  logic [15:0] ohnd_q, ohnd_d;

  logic [95:0] cmem [CACHE_ENTRIES];
  logic [95:0] crd_q, c_wd;
  logic        c_re, c_we;
  logic [CIW-1:0] c_ra, c_wa;
  logic [47:0] pmem [PENDING_IPS];
  logic [47:0] prd_q, p_wd;
  logic        p_re, p_we;
  logic [PIW-1:0] p_ra, p_wa;
  logic [15:0] hmem [HDEPTH];
  logic [15:0] hrd_q, h_wd;
  logic        h_re, h_we;
  logic [HAW-1:0] h_ra, h_wa;

  logic        in_acc, out_free, out_load;
  logic        cfree, pfree;
  logic [CIW-1:0] cfree_idx, cidx, cwr;
  logic [PIW-1:0] pfree_idx, pidx;
  logic [31:0] c_ip, p_ip;
  logic [47:0] c_mac;
  logic [15:0] c_age, p_age, c_nage, p_nage;
  logic [16:0] c_sum, p_sum;
  logic        dst_ok;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ov_q || !out_stall_i;
  assign dst_ok     = (frame_dst_mac_i == BCAST_MAC) || (frame_dst_mac_i == own_mac_q);

  assign c_ip  = crd_q[95:64];
  assign c_mac = crd_q[63:16];
  assign c_age = crd_q[15:0];
  assign p_ip  = prd_q[47:16];
  assign p_age = prd_q[15:0];
  assign cidx  = chk_idx_q[CIW-1:0];
  assign pidx  = chk_idx_q[PIW-1:0];
  assign c_sum = {1'b0, c_age} + {1'b0, dly_q};
  assign p_sum = {1'b0, p_age} + {1'b0, dly_q};
  assign c_nage = c_sum[16] ? 16'hFFFF : c_sum[15:0];
  assign p_nage = p_sum[16] ? 16'hFFFF : p_sum[15:0];
  assign cwr = hit_q ? hit_idx_q : (cfree ? cfree_idx : best_idx_q);

  always_comb begin
    cfree = 1'b0;
    cfree_idx = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (!cv_q[i]) begin
        cfree = 1'b1;
        cfree_idx = CIW'(i);
      end
    end
    pfree = 1'b0;
    pfree_idx = '0;
    for (int i = PENDING_IPS - 1; i >= 0; i--) begin
      if (!pv_q[i]) begin
        pfree = 1'b1;
        pfree_idx = PIW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q; ip_d = ip_q; mac_d = mac_q; hnd_d = hnd_q; dly_d = dly_q;
    reply_d = reply_q;
    cnt_d = cnt_q; chk_idx_d = cnt_q; chk_vld_d = 1'b0;
    hit_d = hit_q; hit_idx_d = hit_idx_q; hit_mac_d = hit_mac_q;
    best_age_d = best_age_q; best_idx_d = best_idx_q;
    phit_d = phit_q; phit_idx_d = phit_idx_q;
    cv_d = cv_q; pv_d = pv_q; pc_d = pc_q;
    fl_p_d = fl_p_q; fl_k_d = fl_k_q; fl_n_d = fl_n_q;
    res_kind_d = res_kind_q; res_dst_d = res_dst_q; res_tip_d = res_tip_q;
    res_tmac_d = res_tmac_q; res_hnd_d = res_hnd_q;
    out_load = 1'b0;
    okind_d = okind_q; odst_d = odst_q; otip_d = otip_q; otmac_d = otmac_q;
    ohnd_d = ohnd_q; olast_d = olast_q;
    c_re = 1'b0; c_ra = cnt_q[CIW-1:0]; c_we = 1'b0; c_wa = cidx; c_wd = crd_q;
    p_re = 1'b0; p_ra = cnt_q[PIW-1:0]; p_we = 1'b0; p_wa = pidx; p_wd = prd_q;
    h_re = 1'b0; h_we = 1'b0;
    h_ra = HAW'(HAW'(fl_p_q) * HAW'(PENDING_PER_IP) + HAW'(fl_k_q));
    h_wa = h_ra; h_wd = hnd_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d = cmd_i; ip_d = peer_ip_i; mac_d = peer_mac_i;
          hnd_d = datagram_handle_i; dly_d = elapsed_ms_i;
          reply_d = (arp_opcode_i == OP_REQUEST) && (asked_ip_i == own_ip_q);
          cnt_d = '0; hit_d = 1'b0; phit_d = 1'b0;
          priority if (cmd_i == CMD_SEND) begin
            state_d = S_CSCAN;
          end else if (cmd_i == CMD_RECV && dst_ok && payload_ok_i &&
                       frame_type_i == FT_IPV4) begin
            res_kind_d = KIND_DELIVER; res_dst_d = '0; res_tip_d = '0;
            res_tmac_d = '0; res_hnd_d = datagram_handle_i;
            state_d = S_EMIT;
          end else if (cmd_i == CMD_RECV && dst_ok && payload_ok_i &&
                       frame_type_i == FT_ARP) begin
            state_d = S_CSCAN;
          end else if (cmd_i == CMD_TICK) begin
            state_d = S_TKC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CSCAN, S_TKC: begin
        if (cnt_q < SW'(CACHE_ENTRIES)) begin
          c_re = 1'b1;
          cnt_d = cnt_q + SW'(1);
          chk_vld_d = 1'b1;
        end
        if (chk_vld_q) begin
          if (state_q == S_CSCAN) begin
            if (!hit_q && cv_q[cidx] && c_ip == ip_q) begin
              hit_d = 1'b1; hit_idx_d = cidx; hit_mac_d = c_mac;
            end
            if (chk_idx_q == '0 || c_age > best_age_q) begin
              best_age_d = c_age; best_idx_d = cidx;
            end
          end else if (cv_q[cidx]) begin
            c_we = 1'b1;
            c_wd = {c_ip, c_mac, c_nage};
            if (c_nage >= cache_life_q) cv_d[cidx] = 1'b0;
          end
        end
        if (cnt_q == SW'(CACHE_ENTRIES) && !chk_vld_q) begin
          cnt_d = '0;
          state_d = (state_q == S_CSCAN) ? S_CDONE : S_TKP;
        end
      end
      S_CDONE: begin
        if (cmd_q == CMD_SEND && hit_q) begin
          res_kind_d = KIND_IPV4; res_dst_d = hit_mac_q; res_tip_d = '0;
          res_tmac_d = '0; res_hnd_d = hnd_q;
          state_d = S_EMIT;
        end else begin
          if (cmd_q != CMD_SEND) begin
            c_we = 1'b1; c_wa = cwr; c_wd = {ip_q, mac_q, 16'd0};
            cv_d[cwr] = 1'b1;
          end
          state_d = S_PSCAN;
        end
      end
      S_PSCAN, S_TKP: begin
        if (cnt_q < SW'(PENDING_IPS)) begin
          p_re = 1'b1;
          cnt_d = cnt_q + SW'(1);
          chk_vld_d = 1'b1;
        end
        if (chk_vld_q) begin
          if (state_q == S_PSCAN) begin
            if (!phit_q && pv_q[pidx] && p_ip == ip_q) begin
              phit_d = 1'b1; phit_idx_d = pidx;
            end
          end else if (pv_q[pidx]) begin
            p_we = 1'b1;
            p_wd = {p_ip, p_nage};
            if (p_nage >= pend_life_q) begin
              pv_d[pidx] = 1'b0;
              pc_d[pidx] = '0;
            end
          end
        end
        if (cnt_q == SW'(PENDING_IPS) && !chk_vld_q) begin
          state_d = (state_q == S_PSCAN) ? S_PDONE : S_IDLE;
        end
      end
      S_PDONE: begin
        fl_p_d = phit_idx_q; fl_k_d = '0; fl_n_d = pc_q[phit_idx_q];
        res_kind_d = KIND_REPLY; res_dst_d = mac_q; res_tip_d = ip_q;
        res_tmac_d = mac_q; res_hnd_d = '0;
        state_d = S_IDLE;
        if (cmd_q == CMD_SEND) begin
          if (phit_q) begin
            if (pc_q[phit_idx_q] < CNTW'(PENDING_PER_IP)) begin
              h_we = 1'b1;
              h_wa = HAW'(HAW'(phit_idx_q) * HAW'(PENDING_PER_IP) +
                          HAW'(pc_q[phit_idx_q]));
              pc_d[phit_idx_q] = pc_q[phit_idx_q] + CNTW'(1);
            end
          end else if (pfree) begin
            pv_d[pfree_idx] = 1'b1;
            pc_d[pfree_idx] = CNTW'(1);
            p_we = 1'b1; p_wa = pfree_idx; p_wd = {ip_q, 16'd0};
            h_we = 1'b1; h_wa = HAW'(HAW'(pfree_idx) * HAW'(PENDING_PER_IP));
            res_kind_d = KIND_REQUEST; res_dst_d = BCAST_MAC; res_tip_d = ip_q;
            res_tmac_d = '0;
            state_d = S_EMIT;
          end
        end else if (phit_q && pc_q[phit_idx_q] != '0) begin
          pv_d[phit_idx_q] = 1'b0;
          pc_d[phit_idx_q] = '0;
          state_d = S_FLRD;
        end else begin
          if (phit_q) begin
            pv_d[phit_idx_q] = 1'b0;
          end
          state_d = reply_q ? S_EMIT : S_IDLE;
        end
      end
      S_FLRD: begin
        h_re = 1'b1;
        state_d = S_FLEM;
      end
      S_FLEM: begin
        if (out_free) begin
          out_load = 1'b1;
          okind_d = KIND_IPV4; odst_d = mac_q; otip_d = '0; otmac_d = '0;
          ohnd_d = hrd_q;
          olast_d = (fl_k_q == fl_n_q - CNTW'(1)) && !reply_q;
          fl_k_d = fl_k_q + CNTW'(1);
          if (fl_k_q == fl_n_q - CNTW'(1)) begin
            state_d = reply_q ? S_EMIT : S_IDLE;
          end else begin
            state_d = S_FLRD;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          okind_d = res_kind_q; odst_d = res_dst_q; otip_d = res_tip_q;
          otmac_d = res_tmac_q; ohnd_d = res_hnd_q; olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_we) cmem[c_wa] <= c_wd;
    if (c_re) crd_q <= cmem[c_ra];
    if (p_we) pmem[p_wa] <= p_wd;
    if (p_re) prd_q <= pmem[p_ra];
    if (h_we) hmem[h_wa] <= h_wd;
    if (h_re) hrd_q <= hmem[h_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      own_mac_q <= '0;
      own_ip_q <= '0;
      cache_life_q <= CACHE_LIFE_RST;
      pend_life_q <= PEND_LIFE_RST;
      cnt_q <= '0;
      chk_vld_q <= 1'b0;
      hit_q <= 1'b0;
      phit_q <= 1'b0;
      cv_q <= '0;
      pv_q <= '0;
      for (int i = 0; i < PENDING_IPS; i++) pc_q[i] <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_OWN_MAC:    own_mac_q <= cfg_data_i;
          REG_OWN_IP:     own_ip_q <= cfg_data_i[31:0];
          REG_CACHE_LIFE: cache_life_q <= cfg_data_i[15:0];
          REG_PEND_LIFE:  pend_life_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      cnt_q <= cnt_d;
      chk_vld_q <= chk_vld_d;
      hit_q <= hit_d;
      phit_q <= phit_d;
      cv_q <= cv_d;
      pv_q <= pv_d;
      pc_q <= pc_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; ip_q <= ip_d; mac_q <= mac_d; hnd_q <= hnd_d; dly_q <= dly_d;
    reply_q <= reply_d;
    chk_idx_q <= chk_idx_d;
    hit_idx_q <= hit_idx_d; hit_mac_q <= hit_mac_d;
    best_age_q <= best_age_d; best_idx_q <= best_idx_d;
    phit_idx_q <= phit_idx_d;
    fl_p_q <= fl_p_d; fl_k_q <= fl_k_d; fl_n_q <= fl_n_d;
    res_kind_q <= res_kind_d; res_dst_q <= res_dst_d; res_tip_q <= res_tip_d;
    res_tmac_q <= res_tmac_d; res_hnd_q <= res_hnd_d;
    okind_q <= okind_d; odst_q <= odst_d; otip_q <= otip_d; otmac_q <= otmac_d;
    ohnd_q <= ohnd_d; olast_q <= olast_d;
  end

  assign out_valid_o      = ov_q;
  assign out_kind_o       = okind_q;
  assign out_dst_mac_o    = odst_q;
  assign out_target_ip_o  = otip_q;
  assign out_target_mac_o = otmac_q;
  assign out_handle_o     = ohnd_q;
  assign last_o           = olast_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free) else $error("result loaded over a waiting result");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == CMD_SEND || cmd_i == CMD_TICK)) |=> in_stall_o)
    else $error("send or tick item finished in one cycle");
  a_flush_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLEM) |-> (fl_k_q < fl_n_q)) else $error("flush ran past its queue");
  a_pend_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(pv_q) <= PENDING_IPS))
    else $error("pending occupancy out of range");

endmodule
`default_nettype wire
